>>> rtl/tae_pkg.sv
package tae_pkg;

  localparam int unsigned MaxTri = 4096;
  localparam int unsigned IdxW   = $clog2(MaxTri);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned VtxW   = 16;
  localparam int unsigned GrpW   = 8;
  localparam int unsigned NbrW   = 16;
  localparam int unsigned UnmW   = 14;
  localparam int unsigned FlgW   = 3;

  localparam logic [NbrW-1:0] NoNbr = '1;

  localparam int unsigned FlagDeg = 0;
  localparam int unsigned FlagCor = 1;
  localparam int unsigned FlagCon = 2;

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpCompute = 2'd1,
    OpRead    = 2'd2,
    OpClear   = 2'd3
  } op_e;

  typedef struct packed {
    logic load_tri;
    logic clear;
    logic start_compute;
    logic read_start;
    logic row_start;
    logic row_latch;
    logic issue;
    logic row_end;
    logic out_load;
    logic out_sel_read;
  } tae_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic i_last;
    logic j_more;
    logic out_free;
  } tae_sts_t;

  function automatic logic is_degen(logic [VtxW-1:0] a, logic [VtxW-1:0] b,
                                    logic [VtxW-1:0] c);
    return (a == b) || (b == c) || (c == a);
  endfunction

endpackage

>>> rtl/tae_ctrl.sv
module tae_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        operation_i,
  output logic              in_ready_o,
  input  tae_pkg::tae_sts_t sts_i,
  output tae_pkg::tae_cmd_t cmd_o
);
  import tae_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SReadWait,
    SReadOut,
    SRowStart,
    SRowLatch,
    SScan,
    SRowEnd,
    SDone
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == SIdle);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OpLoad: cmd_o.load_tri = 1'b1;
            OpClear: cmd_o.clear = 1'b1;
            OpCompute: begin
              cmd_o.start_compute = 1'b1;
              state_d = sts_i.cnt_zero ? SDone : SRowStart;
            end
            OpRead: begin
              cmd_o.read_start = 1'b1;
              state_d = SReadWait;
            end
            default: state_d = SIdle;
          endcase
        end
      end
      SReadWait: state_d = SReadOut;
      SReadOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_sel_read = 1'b1;
          state_d            = SIdle;
        end
      end
      SRowStart: begin
        cmd_o.row_start = 1'b1;
        state_d         = SRowLatch;
      end
      SRowLatch: begin
        cmd_o.row_latch = 1'b1;
        cmd_o.issue     = 1'b1;
        state_d         = SScan;
      end
      SScan: begin
        if (sts_i.j_more) begin
          cmd_o.issue = 1'b1;
        end else begin
          state_d = SRowEnd;
        end
      end
      SRowEnd: begin
        cmd_o.row_end = 1'b1;
        state_d       = sts_i.i_last ? SDone : SRowStart;
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tae_datapath.sv
module tae_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tae_pkg::tae_cmd_t          cmd_i,
  output tae_pkg::tae_sts_t          sts_o,
  input  logic [tae_pkg::VtxW-1:0]   vertex_a_i,
  input  logic [tae_pkg::VtxW-1:0]   vertex_b_i,
  input  logic [tae_pkg::VtxW-1:0]   vertex_c_i,
  input  logic [tae_pkg::GrpW-1:0]   group_number_i,
  input  logic [tae_pkg::IdxW-1:0]   read_index_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [tae_pkg::NbrW-1:0]   neighbour_ab_o,
  output logic [tae_pkg::NbrW-1:0]   neighbour_bc_o,
  output logic [tae_pkg::NbrW-1:0]   neighbour_ca_o,
  output logic                       degenerate_flag_o,
  output logic                       corrected_flag_o,
  output logic                       conflict_flag_o,
  output logic                       invalid_read_o,
  output logic [tae_pkg::UnmW-1:0]   unmatched_edges_o,
  output logic [tae_pkg::CntW-1:0]   loaded_count_o,
  output logic                       overflow_flag_o
);
  import tae_pkg::*;

  logic [3*VtxW-1:0] vert_mem [MaxTri];
  logic [GrpW-1:0]   grp_mem  [MaxTri];
  logic [3*NbrW-1:0] nbr_mem  [MaxTri];
  logic [FlgW-1:0]   flg_mem  [MaxTri];

  logic                  grp_en_q;
  logic [CntW-1:0]       count_q;
  logic                  ovf_q;
  logic [IdxW-1:0]       i_q;
  logic [CntW-1:0]       j_q;
  logic [UnmW-1:0]       unm_q;
  logic                  cand_valid_q;
  logic [IdxW-1:0]       cand_idx_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  out_valid_q;

  logic [2:0][VtxW-1:0]  rv_q;
  logic [GrpW-1:0]       rg_q;
  logic [2:0][NbrW-1:0]  nb_q, nb_d;
  logic [2:0]            same_q, same_d;
  logic [FlgW-1:0]       flg_q, flg_d;

  logic [2:0][VtxW-1:0]  vert_rd_q;
  logic [GrpW-1:0]       grp_rd_q;
  logic [2:0][NbrW-1:0]  nbr_rd_q;
  logic [FlgW-1:0]       flg_rd_q;

  logic [IdxW-1:0]       vert_raddr;
  logic                  full;
  logic                  load_ok;
  logic                  load_deg;
  logic [2:0]            hit;
  logic                  new_same;
  logic                  cand_use;
  logic [2:0]            miss;
  logic [1:0]            miss_cnt;
  logic                  rd_invalid;
  logic                  out_free;
  logic [IdxW-1:0]       wr_addr;
  logic                  nbr_we;
  logic [3*NbrW-1:0]     nbr_wdata;
  logic [FlgW-1:0]       flg_wdata;

  assign full       = (count_q == CntW'(MaxTri));
  assign load_ok    = cmd_i.load_tri && !full;
  assign load_deg   = is_degen(vertex_a_i, vertex_b_i, vertex_c_i);
  assign vert_raddr = cmd_i.issue ? j_q[IdxW-1:0] : i_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_invalid = ({1'b0, rd_idx_q} >= count_q);

  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.i_last   = (({1'b0, i_q} + CntW'(1)) == count_q);
  assign sts_o.j_more   = (j_q < count_q);
  assign sts_o.out_free = out_free;

  // candidate match and slot update
  always_comb begin
    logic [VtxW-1:0] ea;
    logic [VtxW-1:0] eb;
    nb_d     = nb_q;
    same_d   = same_q;
    flg_d    = flg_q;
    new_same = (grp_rd_q == rg_q);
    cand_use = cand_valid_q && (cand_idx_q != i_q);
    for (int k = 0; k < 3; k++) begin
      ea = rv_q[k];
      eb = rv_q[(k == 2) ? 0 : k + 1];
      hit[k] = (eb == vert_rd_q[0] && ea == vert_rd_q[1]) ||
               (eb == vert_rd_q[1] && ea == vert_rd_q[2]) ||
               (eb == vert_rd_q[2] && ea == vert_rd_q[0]);
      if (cand_use && hit[k]) begin
        if (nb_q[k] == NoNbr) begin
          nb_d[k]   = NbrW'(cand_idx_q);
          same_d[k] = new_same;
        end else if (grp_en_q && same_q[k] && !new_same) begin
          flg_d[FlagCor] = 1'b1;
        end else if (grp_en_q && !same_q[k] && new_same) begin
          nb_d[k]        = NbrW'(cand_idx_q);
          same_d[k]      = 1'b1;
          flg_d[FlagCor] = 1'b1;
        end else begin
          flg_d[FlagCon] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      miss[k] = (nb_q[k] == NoNbr);
    end
    miss_cnt = {1'b0, miss[0]} + {1'b0, miss[1]} + {1'b0, miss[2]};
  end

  always_comb begin
    if (cmd_i.row_end) begin
      wr_addr   = i_q;
      nbr_we    = 1'b1;
      nbr_wdata = nb_q;
      flg_wdata = flg_q;
    end else begin
      wr_addr   = count_q[IdxW-1:0];
      nbr_we    = load_ok;
      nbr_wdata = {NoNbr, NoNbr, NoNbr};
      flg_wdata = '0;
      flg_wdata[FlagDeg] = load_deg;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      vert_mem[count_q[IdxW-1:0]] <= {vertex_c_i, vertex_b_i, vertex_a_i};
      grp_mem[count_q[IdxW-1:0]]  <= group_number_i;
    end
    if (nbr_we) begin
      nbr_mem[wr_addr] <= nbr_wdata;
      flg_mem[wr_addr] <= flg_wdata;
    end
    vert_rd_q <= vert_mem[vert_raddr];
    grp_rd_q  <= grp_mem[vert_raddr];
    nbr_rd_q  <= nbr_mem[rd_idx_q];
    flg_rd_q  <= flg_mem[rd_idx_q];
  end

  // row and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_start) begin
      rd_idx_q <= read_index_i;
    end
    if (cmd_i.issue) begin
      cand_idx_q <= j_q[IdxW-1:0];
    end
    if (cmd_i.row_latch) begin
      rv_q   <= vert_rd_q;
      rg_q   <= grp_rd_q;
      nb_q   <= {NoNbr, NoNbr, NoNbr};
      same_q <= '0;
      flg_q  <= FlgW'(is_degen(vert_rd_q[0], vert_rd_q[1], vert_rd_q[2])) << FlagDeg;
    end else begin
      nb_q   <= nb_d;
      same_q <= same_d;
      flg_q  <= flg_d;
    end
    if (cmd_i.out_load) begin
      loaded_count_o  <= count_q;
      overflow_flag_o <= ovf_q;
      if (cmd_i.out_sel_read) begin
        unmatched_edges_o <= '0;
        invalid_read_o    <= rd_invalid;
        if (rd_invalid) begin
          neighbour_ab_o    <= NoNbr;
          neighbour_bc_o    <= NoNbr;
          neighbour_ca_o    <= NoNbr;
          degenerate_flag_o <= 1'b0;
          corrected_flag_o  <= 1'b0;
          conflict_flag_o   <= 1'b0;
        end else begin
          neighbour_ab_o    <= nbr_rd_q[0];
          neighbour_bc_o    <= nbr_rd_q[1];
          neighbour_ca_o    <= nbr_rd_q[2];
          degenerate_flag_o <= flg_rd_q[FlagDeg];
          corrected_flag_o  <= flg_rd_q[FlagCor];
          conflict_flag_o   <= flg_rd_q[FlagCon];
        end
      end else begin
        unmatched_edges_o <= unm_q;
        invalid_read_o    <= 1'b0;
        neighbour_ab_o    <= NoNbr;
        neighbour_bc_o    <= NoNbr;
        neighbour_ca_o    <= NoNbr;
        degenerate_flag_o <= 1'b0;
        corrected_flag_o  <= 1'b0;
        conflict_flag_o   <= 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_en_q     <= 1'b1;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      unm_q        <= '0;
      cand_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        grp_en_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load_tri) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
      if (cmd_i.start_compute) begin
        i_q   <= '0;
        unm_q <= '0;
      end else if (cmd_i.row_end) begin
        i_q   <= i_q + IdxW'(1);
        unm_q <= unm_q + UnmW'(miss_cnt);
      end
      if (cmd_i.row_start) begin
        j_q <= '0;
      end else if (cmd_i.issue) begin
        j_q <= j_q + CntW'(1);
      end
      cand_valid_q <= cmd_i.issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/triangle_edge_adjacency_unit.sv
// Triangle edge adjacency. Requests are taken one at a time; loads stream at one per cycle.
// A read passes through the registered read of the neighbor store and waits for the output
// register to be free. A compute walks every triangle pair through the single read port of
// the triangle store. Compute and read return one result each through an output register; load
// and clear return none. The group tie-break register is written through the configuration
// channel; the user must do so only while idle, since the block does not enforce it.
module triangle_edge_adjacency_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [tae_pkg::VtxW-1:0]   vertex_a_i,
  input  logic [tae_pkg::VtxW-1:0]   vertex_b_i,
  input  logic [tae_pkg::VtxW-1:0]   vertex_c_i,
  input  logic [tae_pkg::GrpW-1:0]   group_number_i,
  input  logic [tae_pkg::IdxW-1:0]   read_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tae_pkg::NbrW-1:0]   neighbour_ab_o,
  output logic [tae_pkg::NbrW-1:0]   neighbour_bc_o,
  output logic [tae_pkg::NbrW-1:0]   neighbour_ca_o,
  output logic                       degenerate_flag_o,
  output logic                       corrected_flag_o,
  output logic                       conflict_flag_o,
  output logic                       invalid_read_o,
  output logic [tae_pkg::UnmW-1:0]   unmatched_edges_o,
  output logic [tae_pkg::CntW-1:0]   loaded_count_o,
  output logic                       overflow_flag_o
);
  import tae_pkg::*;

  tae_cmd_t cmd;
  tae_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tae_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .vertex_c_i        (vertex_c_i),
    .group_number_i    (group_number_i),
    .read_index_i      (read_index_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .neighbour_ab_o    (neighbour_ab_o),
    .neighbour_bc_o    (neighbour_bc_o),
    .neighbour_ca_o    (neighbour_ca_o),
    .degenerate_flag_o (degenerate_flag_o),
    .corrected_flag_o  (corrected_flag_o),
    .conflict_flag_o   (conflict_flag_o),
    .invalid_read_o    (invalid_read_o),
    .unmatched_edges_o (unmatched_edges_o),
    .loaded_count_o    (loaded_count_o),
    .overflow_flag_o   (overflow_flag_o)
  );

endmodule

>>> bench/triangle_edge_adjacency_unit_tb.sv
module triangle_edge_adjacency_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tae_pkg::*;

  typedef struct packed {
    logic [NbrW-1:0] nbr_ab;
    logic [NbrW-1:0] nbr_bc;
    logic [NbrW-1:0] nbr_ca;
    logic            deg;
    logic            cor;
    logic            con;
    logic            inv;
    logic [UnmW-1:0] unm;
    logic [CntW-1:0] cnt;
    logic            ovf;
  } adj_result_t;

  typedef struct {
    op_e             op;
    logic [VtxW-1:0] va;
    logic [VtxW-1:0] vb;
    logic [VtxW-1:0] vc;
    logic [GrpW-1:0] grp;
    logic [IdxW-1:0] idx;
    bit              typed;
    adj_result_t     res;
  } stim_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_data_i = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      operation_i = OpLoad;
  logic [VtxW-1:0] vertex_a_i = '0;
  logic [VtxW-1:0] vertex_b_i = '0;
  logic [VtxW-1:0] vertex_c_i = '0;
  logic [GrpW-1:0] group_number_i = '0;
  logic [IdxW-1:0] read_index_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [NbrW-1:0] neighbour_ab_o;
  logic [NbrW-1:0] neighbour_bc_o;
  logic [NbrW-1:0] neighbour_ca_o;
  logic            degenerate_flag_o;
  logic            corrected_flag_o;
  logic            conflict_flag_o;
  logic            invalid_read_o;
  logic [UnmW-1:0] unmatched_edges_o;
  logic [CntW-1:0] loaded_count_o;
  logic            overflow_flag_o;

  triangle_edge_adjacency_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .vertex_a_i,
    .vertex_b_i,
    .vertex_c_i,
    .group_number_i,
    .read_index_i,
    .out_valid_o,
    .out_ready_i,
    .neighbour_ab_o,
    .neighbour_bc_o,
    .neighbour_ca_o,
    .degenerate_flag_o,
    .corrected_flag_o,
    .conflict_flag_o,
    .invalid_read_o,
    .unmatched_edges_o,
    .loaded_count_o,
    .overflow_flag_o
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  logic [VtxW-1:0] tri_vtx [MaxTri][3];
  logic [GrpW-1:0] tri_grp [MaxTri];
  logic [NbrW-1:0] tri_nbr [MaxTri][3];
  logic [FlgW-1:0] tri_flag [MaxTri];
  int unsigned     tri_count = 0;
  bit              ovf_seen = 1'b0;
  bit              resolve_en = 1'b1;

  adj_result_t pending_results [$];
  stim_row_t   directed_rows [$];

  int n_loads = 0, n_computes = 0, n_reads = 0, n_clears = 0, n_cfg = 0;
  int n_checked = 0, mismatches = 0, unexpected = 0;
  int burst_left = 0;
  int hold_token = 0, hold_seen = 0, hold_left = 0;
  int rx_mode = 0, mode_left = 0;

  function automatic bit tri_is_flat(int unsigned t);
    return tri_vtx[t][0] == tri_vtx[t][1] || tri_vtx[t][1] == tri_vtx[t][2] ||
           tri_vtx[t][2] == tri_vtx[t][0];
  endfunction

  function automatic bit holds_reversed(logic [VtxW-1:0] ea, logic [VtxW-1:0] eb,
                                        int unsigned t);
    return (eb == tri_vtx[t][0] && ea == tri_vtx[t][1]) ||
           (eb == tri_vtx[t][1] && ea == tri_vtx[t][2]) ||
           (eb == tri_vtx[t][2] && ea == tri_vtx[t][0]);
  endfunction

  function automatic void offer_neighbour(int unsigned t, int s, int unsigned cand);
    logic [NbrW-1:0] cur;
    bit cur_same, new_same;
    cur = tri_nbr[t][s];
    if (cur == NoNbr) begin
      tri_nbr[t][s] = cand[NbrW-1:0];
      return;
    end
    if (resolve_en && cur < MaxTri) begin
      cur_same = tri_grp[t] == tri_grp[cur];
      new_same = tri_grp[t] == tri_grp[cand];
      if (cur_same && !new_same) begin
        tri_flag[t][FlagCor] = 1'b1;
        return;
      end
      if (!cur_same && new_same) begin
        tri_nbr[t][s] = cand[NbrW-1:0];
        tri_flag[t][FlagCor] = 1'b1;
        return;
      end
    end
    tri_flag[t][FlagCon] = 1'b1;
  endfunction

  function automatic void predict_adjacency(input op_e op, input logic [VtxW-1:0] va,
                                            input logic [VtxW-1:0] vb,
                                            input logic [VtxW-1:0] vc,
                                            input logic [GrpW-1:0] grp,
                                            input logic [IdxW-1:0] idx,
                                            output bit has_result, output adj_result_t r);
    int unsigned unm;
    has_result = 1'b0;
    unm = 0;
    r = '0;
    r.nbr_ab = NoNbr;
    r.nbr_bc = NoNbr;
    r.nbr_ca = NoNbr;
    case (op)
      OpLoad: begin
        if (tri_count >= MaxTri) begin
          ovf_seen = 1'b1;
        end else begin
          tri_vtx[tri_count][0] = va;
          tri_vtx[tri_count][1] = vb;
          tri_vtx[tri_count][2] = vc;
          tri_grp[tri_count] = grp;
          for (int s = 0; s < 3; s++) tri_nbr[tri_count][s] = NoNbr;
          tri_flag[tri_count] = '0;
          tri_flag[tri_count][FlagDeg] = tri_is_flat(tri_count);
          tri_count++;
        end
      end
      OpClear: begin
        tri_count = 0;
        ovf_seen = 1'b0;
      end
      OpCompute: begin
        has_result = 1'b1;
        for (int unsigned i = 0; i < tri_count; i++) begin
          for (int s = 0; s < 3; s++) tri_nbr[i][s] = NoNbr;
          tri_flag[i] = '0;
          tri_flag[i][FlagDeg] = tri_is_flat(i);
          for (int unsigned j = 0; j < tri_count; j++) begin
            if (j != i) begin
              if (holds_reversed(tri_vtx[i][0], tri_vtx[i][1], j)) offer_neighbour(i, 0, j);
              if (holds_reversed(tri_vtx[i][1], tri_vtx[i][2], j)) offer_neighbour(i, 1, j);
              if (holds_reversed(tri_vtx[i][2], tri_vtx[i][0], j)) offer_neighbour(i, 2, j);
            end
          end
        end
        for (int unsigned i = 0; i < tri_count; i++)
          for (int s = 0; s < 3; s++)
            if (tri_nbr[i][s] == NoNbr) unm++;
        r.unm = unm[UnmW-1:0];
      end
      default: begin
        has_result = 1'b1;
        if (idx >= tri_count) begin
          r.inv = 1'b1;
        end else begin
          r.nbr_ab = tri_nbr[idx][0];
          r.nbr_bc = tri_nbr[idx][1];
          r.nbr_ca = tri_nbr[idx][2];
          r.deg = tri_flag[idx][FlagDeg];
          r.cor = tri_flag[idx][FlagCor];
          r.con = tri_flag[idx][FlagCon];
        end
      end
    endcase
    r.cnt = tri_count[CntW-1:0];
    r.ovf = ovf_seen;
  endfunction

  function automatic adj_result_t make_result(logic [NbrW-1:0] ab, logic [NbrW-1:0] bc,
                                              logic [NbrW-1:0] ca, logic deg, logic cor,
                                              logic con, logic inv, logic [UnmW-1:0] unm,
                                              logic [CntW-1:0] cnt, logic ovf);
    adj_result_t r;
    r = '{ab, bc, ca, deg, cor, con, inv, unm, cnt, ovf};
    return r;
  endfunction

  function automatic void add_row(op_e op, logic [VtxW-1:0] va, logic [VtxW-1:0] vb,
                                  logic [VtxW-1:0] vc, logic [GrpW-1:0] grp,
                                  logic [IdxW-1:0] idx, bit typed, adj_result_t res);
    stim_row_t row;
    row = '{op, va, vb, vc, grp, idx, typed, res};
    directed_rows.push_back(row);
  endfunction

  task automatic send_request(input op_e op, input logic [VtxW-1:0] va,
                              input logic [VtxW-1:0] vb, input logic [VtxW-1:0] vc,
                              input logic [GrpW-1:0] grp, input logic [IdxW-1:0] idx,
                              input bit typed, input adj_result_t typed_res);
    bit has;
    adj_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    vertex_a_i <= va;
    vertex_b_i <= vb;
    vertex_c_i <= vc;
    group_number_i <= grp;
    read_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    case (op)
      OpLoad:    n_loads++;
      OpCompute: n_computes++;
      OpRead:    n_reads++;
      default:   n_clears++;
    endcase
    predict_adjacency(op, va, vb, vc, grp, idx, has, r);
    if (has) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send_plain(input op_e op, input logic [VtxW-1:0] va,
                            input logic [VtxW-1:0] vb, input logic [VtxW-1:0] vc,
                            input logic [GrpW-1:0] grp, input logic [IdxW-1:0] idx);
    send_request(op, va, vb, vc, grp, idx, 1'b0, '0);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_resolve(input bit en);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    resolve_en = en;
    n_cfg++;
  endtask

  function automatic logic [VtxW-1:0] pool_vertex(logic [VtxW-1:0] base, int pool);
    if ($urandom_range(0, 11) == 0) return VtxW'($urandom);
    return base + VtxW'($urandom_range(0, pool - 1));
  endfunction

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    adj_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        unexpected++;
        $display("result with no request waiting");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("neighbour_ab", 32'(want.nbr_ab), 32'(neighbour_ab_o));
        check_field("neighbour_bc", 32'(want.nbr_bc), 32'(neighbour_bc_o));
        check_field("neighbour_ca", 32'(want.nbr_ca), 32'(neighbour_ca_o));
        check_field("degenerate_flag", 32'(want.deg), 32'(degenerate_flag_o));
        check_field("corrected_flag", 32'(want.cor), 32'(corrected_flag_o));
        check_field("conflict_flag", 32'(want.con), 32'(conflict_flag_o));
        check_field("invalid_read", 32'(want.inv), 32'(invalid_read_o));
        check_field("unmatched_edges", 32'(want.unm), 32'(unmatched_edges_o));
        check_field("loaded_count", 32'(want.cnt), 32'(loaded_count_o));
        check_field("overflow_flag", 32'(want.ovf), 32'(overflow_flag_o));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int random_items, phase, n, m, pool, t, k, leftover;
    logic [VtxW-1:0] base, va, vb, vc;
    logic [GrpW-1:0] g0, g1, grp;
    logic [IdxW-1:0] idx;
    random_items = 0;
    phase = 0;

    add_row(OpRead, 0, 0, 0, 0, 12'd0, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 0, 0, 0, 1, 0, 0, 0));
    add_row(OpRead, 0, 0, 0, 0, 12'hFFF, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 0, 0, 0, 1, 0, 0, 0));
    add_row(OpCompute, 0, 0, 0, 0, 0, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 0, 0, 0, 0, 0, 0, 0));
    add_row(OpLoad, 16'd0, 16'd1, 16'd2, 8'h00, 0, 1'b0, '0);
    add_row(OpLoad, 16'd1, 16'd0, 16'd3, 8'h00, 0, 1'b0, '0);
    add_row(OpLoad, 16'd2, 16'd1, 16'hFFFF, 8'hFF, 0, 1'b0, '0);
    add_row(OpLoad, 16'd5, 16'd5, 16'd7, 8'h01, 0, 1'b0, '0);
    add_row(OpLoad, 16'd1, 16'd0, 16'd9, 8'hFF, 0, 1'b0, '0);
    add_row(OpLoad, 16'd2, 16'd1, 16'h10, 8'h00, 0, 1'b0, '0);
    add_row(OpLoad, 16'd0, 16'd2, 16'h20, 8'h00, 0, 1'b0, '0);
    add_row(OpLoad, 16'd0, 16'd2, 16'h21, 8'h00, 0, 1'b0, '0);
    add_row(OpRead, 0, 0, 0, 0, 12'd0, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 0, 0, 0, 0, 0, 8, 0));
    add_row(OpRead, 0, 0, 0, 0, 12'd3, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 1, 0, 0, 0, 0, 8, 0));
    add_row(OpRead, 0, 0, 0, 0, 12'd8, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 0, 0, 0, 1, 0, 8, 0));
    add_row(OpCompute, 0, 0, 0, 0, 0, 1'b0, '0);
    for (int i = 0; i < 4; i++) add_row(OpRead, 0, 0, 0, 0, IdxW'(i), 1'b0, '0);
    add_row(OpClear, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(OpRead, 0, 0, 0, 0, 12'd0, 1'b1,
            make_result(NoNbr, NoNbr, NoNbr, 0, 0, 0, 1, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].va, directed_rows[i].vb,
                   directed_rows[i].vc, directed_rows[i].grp, directed_rows[i].idx,
                   directed_rows[i].typed, directed_rows[i].res);

    while (random_items < 950) begin
      if (phase < 2) write_resolve(phase[0]);
      else if ($urandom_range(0, 2) == 0) write_resolve(1'($urandom_range(0, 1)));
      if (tri_count > 28 || $urandom_range(0, 3) == 0) begin
        send_plain(OpClear, 0, 0, 0, 0, 0);
        random_items++;
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      if (tri_count + n > 40) n = 40 - tri_count;
      if (phase == 3) hold_token <= hold_token + 1;
      base = VtxW'($urandom);
      pool = $urandom_range(3, 9);
      g0 = GrpW'($urandom);
      g1 = ($urandom_range(0, 3) == 0) ? g0 : GrpW'($urandom);
      repeat (n) begin
        if (tri_count != 0 && $urandom_range(0, 1) == 1) begin
          t = $urandom_range(0, tri_count - 1);
          k = $urandom_range(0, 2);
          va = tri_vtx[t][(k + 1) % 3];
          vb = tri_vtx[t][k];
          vc = pool_vertex(base, pool);
        end else begin
          va = pool_vertex(base, pool);
          vb = pool_vertex(base, pool);
          vc = pool_vertex(base, pool);
        end
        grp = ($urandom_range(0, 9) == 0) ? GrpW'($urandom) :
              ($urandom_range(0, 1) == 1) ? g1 : g0;
        send_plain(OpLoad, va, vb, vc, grp, 0);
        random_items++;
        if ($urandom_range(0, 5) == 0) begin
          send_plain(OpRead, 0, 0, 0, 0, IdxW'($urandom_range(0, tri_count)));
          random_items++;
        end
        if ($urandom_range(0, 29) == 0) begin
          send_plain(op_e'($urandom_range(0, 3)), VtxW'($urandom), VtxW'($urandom),
                     VtxW'($urandom), GrpW'($urandom), IdxW'($urandom));
          random_items++;
        end
      end
      if ($urandom_range(0, 7) != 0) begin
        send_plain(OpCompute, 0, 0, 0, 0, 0);
        random_items++;
      end
      m = $urandom_range(1, tri_count + 2);
      repeat (m) begin
        idx = ($urandom_range(0, 7) == 0) ? IdxW'($urandom) :
              IdxW'($urandom_range(0, tri_count + 1));
        send_plain(OpRead, 0, 0, 0, 0, idx);
        random_items++;
      end
      phase++;
    end

    wait_idle();
    leftover = pending_results.size();
    $display("ran %0d loads, %0d computes, %0d reads, %0d clears, %0d group-mode writes",
             n_loads, n_computes, n_reads, n_clears, n_cfg);
    $display("checked %0d results: %0d field mismatches, %0d unexpected, %0d missing",
             n_checked, mismatches, unexpected, leftover);
    if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
